FILE: rtl/rv32i_pkg.sv
// Package for the RV32I executor: opcodes, status codes, queue entry type.
// No dependencies.
`default_nettype none
package rv32i_pkg;
    localparam int DMEM_WORDS_DEF = 1024;

    localparam logic [6:0] OP_LUI    = 7'h37;
    localparam logic [6:0] OP_AUIPC  = 7'h17;
    localparam logic [6:0] OP_JAL    = 7'h6F;
    localparam logic [6:0] OP_JALR   = 7'h67;
    localparam logic [6:0] OP_BRANCH = 7'h63;
    localparam logic [6:0] OP_LOAD   = 7'h03;
    localparam logic [6:0] OP_STORE  = 7'h23;
    localparam logic [6:0] OP_IMM    = 7'h13;
    localparam logic [6:0] OP_REG    = 7'h33;

    localparam logic [6:0] F7_ZERO = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNSUP     = 2'd1;
    localparam logic [1:0] ST_MISALIGN  = 2'd2;

    localparam int RES_W = 32 + 32 + 5 + 32 + 1 + 1 + 1 + 32 + 2;
    localparam int RES_BYTES_W = ((RES_W + 7) / 8) * 8;

    typedef struct packed {
        logic        legal;
        logic [31:0] word;
    } front_item_t;
endpackage
`default_nettype wire

FILE: rtl/rv32i_instruction_executor.sv
// Top level of the RV32I executor: front classifier and back execution unit.
// Depends on rv32i_pkg, rv32i_front, rv32i_back.
//
// channel | dir | contents
// s_      | in  | tdata[31:0] instr_word
// m_      | out | instr_pc, next_pc, dest_index, dest_value, dest_written,
//         |     | branch_taken, store_done, access_address, status
// cfg     | in  | start_pc, also loads the pc
//
// The data memory read is registered before writeback; a new request is
// not taken while one is in flight. After reset a clearing pass zeroes
// data memory; no request is taken meanwhile. The front register holds one
// request while the back works, and the output register parts the m_ side.
`default_nettype none
module rv32i_instruction_executor #(
    parameter int DMEM_WORDS = rv32i_pkg::DMEM_WORDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [31:0] cfg_wr_data,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // [31:0] instr_word
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [31:0] instr_pc, [63:32] next_pc, [68:64] dest_index, [100:69] dest_value,
    // [101] dest_written, [102] branch_taken, [103] store_done,
    // [135:104] access_address, [137:136] status
    output logic [rv32i_pkg::RES_BYTES_W-1:0] m_tdata
);
    import rv32i_pkg::*;

    logic        q_valid, q_ready;
    front_item_t q_item;

    rv32i_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready, .s_tdata,
        .q_valid, .q_ready, .q_item
    );

    rv32i_back #(.DMEM_WORDS(DMEM_WORDS)) u_back (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_data,
        .q_valid, .q_ready, .q_item, .m_tvalid, .m_tready, .m_tdata
    );

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[137:136] != 2'd3) else $error("bad status");
    a_x0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[101] |-> m_tdata[68:64] != 5'd0) else $error("x0 written");
    a_fault: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[137:136] != 2'd0 |-> !m_tdata[101] && !m_tdata[103])
        else $error("fault with side effect");
endmodule
`default_nettype wire

FILE: rtl/rv32i_front.sv
// Front end: accepts instruction words and classifies them by legality.
// Depends on rv32i_pkg.
`default_nettype none
module rv32i_front (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire logic                      s_tvalid,
    output logic                           s_tready,
    input  wire logic [31:0]               s_tdata,
    output logic                           q_valid,
    input  wire logic                      q_ready,
    output rv32i_pkg::front_item_t         q_item
);
    import rv32i_pkg::*;

    logic        legal;
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [6:0]  f7;
    front_item_t item_reg;
    logic        valid_reg;

    assign op = s_tdata[6:0];
    assign f3 = s_tdata[14:12];
    assign f7 = s_tdata[31:25];

    always_comb begin
        case (op)
            OP_LUI, OP_AUIPC, OP_JAL: legal = 1'b1;
            OP_JALR:   legal = (f3 == 3'd0);
            OP_BRANCH: legal = !(f3 inside {3'd2, 3'd3});
            OP_LOAD:   legal = !(f3 inside {3'd3, 3'd6, 3'd7});
            OP_STORE:  legal = (f3 <= 3'd2);
            OP_IMM:    legal = (f3 == 3'd1) ? (f7 == F7_ZERO) :
                               (f3 == 3'd5) ? (f7 == F7_ZERO || f7 == F7_ALT) : 1'b1;
            OP_REG:    legal = (f7 == F7_ZERO) ||
                               (f7 == F7_ALT && (f3 == 3'd0 || f3 == 3'd5));
            default:   legal = 1'b0;
        endcase
    end

    assign s_tready = !valid_reg || q_ready;
    assign q_valid  = valid_reg;
    assign q_item   = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tready) begin
            valid_reg <= s_tvalid;
        end
        if (s_tready && s_tvalid) begin
            item_reg <= '{legal: legal, word: s_tdata};
        end
    end
endmodule
`default_nettype wire

FILE: rtl/rv32i_back.sv
// Back end: register file, pc, data memory; executes in an accept and a memory phase.
// Depends on rv32i_pkg.
`default_nettype none
module rv32i_back #(
    parameter int DMEM_WORDS = rv32i_pkg::DMEM_WORDS_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     cfg_wr_en,
    input  wire logic [31:0]              cfg_wr_data,
    input  wire logic                     q_valid,
    output logic                          q_ready,
    input  wire rv32i_pkg::front_item_t   q_item,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    output logic [rv32i_pkg::RES_BYTES_W-1:0] m_tdata
);
    import rv32i_pkg::*;
    localparam int AW = $clog2(DMEM_WORDS);
    localparam int CW = AW + 1;

    logic [31:0] rf [32];
    logic [31:0] mem [DMEM_WORDS];
    logic [31:0] pc_reg;
    logic [CW-1:0] clr_reg;
    logic        clearing;

    // stage: 0 idle/accept, 1 memory and writeback phase
    logic        busy_reg;
    logic [31:0] w_reg, pc1_reg, b_reg, addr_reg, val1_reg, next1_reg;
    logic [1:0]  st1_reg;
    logic        wr1_reg, tk1_reg, load_reg, store_reg;
    logic [31:0] rdata_reg;
    logic        out_v_reg;
    logic [RES_BYTES_W-1:0] out_reg;

    logic [31:0] w, a, b, imm_i, imm_s, imm_b, imm_j, val, addr, nxt;
    logic [6:0]  op;
    logic [2:0]  f3;
    logic [4:0]  sh;
    logic        wr, tk, cond, lt, ltu, mis, is_ld, is_st;
    logic [1:0]  st;
    logic        take;

    assign clearing = !clr_reg[AW];
    assign w  = q_item.word;
    assign op = w[6:0];
    assign f3 = w[14:12];
    assign a  = (w[19:15] == 5'd0) ? 32'd0 : rf[w[19:15]];
    assign b  = (w[24:20] == 5'd0) ? 32'd0 : rf[w[24:20]];
    assign imm_i = {{20{w[31]}}, w[31:20]};
    assign imm_s = {{20{w[31]}}, w[31:25], w[11:7]};
    assign imm_b = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
    assign imm_j = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};

    always_comb begin
        logic [31:0] opb;
        opb  = (op == OP_REG) ? b : imm_i;
        sh   = opb[4:0];
        lt   = $signed(a) < $signed(opb);
        ltu  = a < opb;
        val = 32'd0; addr = 32'd0; nxt = pc_reg + 32'd4;
        wr = 1'b0; tk = 1'b0; cond = 1'b0; mis = 1'b0; is_ld = 1'b0; is_st = 1'b0;
        case (op)
            OP_LUI:   begin val = {w[31:12], 12'd0}; wr = 1'b1; end
            OP_AUIPC: begin val = pc_reg + {w[31:12], 12'd0}; wr = 1'b1; end
            OP_JAL:   begin val = pc_reg + 32'd4; wr = 1'b1; tk = 1'b1; nxt = pc_reg + imm_j; end
            OP_JALR:  begin
                val = pc_reg + 32'd4; wr = 1'b1; tk = 1'b1;
                nxt = (a + imm_i) & ~32'd1;
            end
            OP_BRANCH: begin
                case (f3)
                    3'd0: cond = (a == b);
                    3'd1: cond = (a != b);
                    3'd4: cond = $signed(a) < $signed(b);
                    3'd5: cond = !($signed(a) < $signed(b));
                    3'd6: cond = a < b;
                    default: cond = a >= b;
                endcase
                if (cond) begin tk = 1'b1; nxt = pc_reg + imm_b; end
            end
            OP_LOAD: begin
                addr = a + imm_i; is_ld = 1'b1; wr = 1'b1;
                mis = (f3[1:0] == 2'd1 && addr[0]) || (f3[1:0] == 2'd2 && addr[1:0] != 2'd0);
            end
            OP_STORE: begin
                addr = a + imm_s; is_st = 1'b1;
                mis = (f3[1:0] == 2'd1 && addr[0]) || (f3[1:0] == 2'd2 && addr[1:0] != 2'd0);
            end
            default: begin
                wr = 1'b1;
                case (f3)
                    3'd0: val = (op == OP_REG && w[30]) ? a - b : a + opb;
                    3'd1: val = a << sh;
                    3'd2: val = {31'd0, lt};
                    3'd3: val = {31'd0, ltu};
                    3'd4: val = a ^ opb;
                    3'd5: val = w[30] ? 32'($signed(a) >>> sh) : a >> sh;
                    3'd6: val = a | opb;
                    default: val = a & opb;
                endcase
            end
        endcase
        st = ST_OK;
        if (!q_item.legal) st = ST_UNSUP;
        else if (mis) st = ST_MISALIGN;
        if (st != ST_OK) begin
            wr = 1'b0; tk = 1'b0; val = 32'd0; nxt = pc_reg + 32'd4;
            is_ld = 1'b0; is_st = 1'b0;
        end
        if (st == ST_UNSUP) addr = 32'd0;
    end

    // one item in flight; output register frees when taken
    assign q_ready = !clearing && !busy_reg && (!out_v_reg || m_tready);
    assign take = q_valid && q_ready;

    logic [AW-1:0] widx;
    logic [31:0]   ld_val, st_word, st_data;
    logic [3:0]    st_be;
    logic [4:0]    rd1;
    logic          wr_eff;
    logic [31:0]   sh_rd, fin_val;

    assign widx = addr_reg[AW+1:2];
    assign rd1  = w_reg[11:7];
    assign sh_rd = rdata_reg >> {addr_reg[1:0], 3'b000};

    always_comb begin
        case (w_reg[14:12])
            3'd0: ld_val = {{24{sh_rd[7]}}, sh_rd[7:0]};
            3'd1: ld_val = {{16{sh_rd[15]}}, sh_rd[15:0]};
            3'd4: ld_val = {24'd0, sh_rd[7:0]};
            3'd5: ld_val = {16'd0, sh_rd[15:0]};
            default: ld_val = rdata_reg;
        endcase
        st_data = b_reg << {addr_reg[1:0], 3'b000};
        case (w_reg[13:12])
            2'd0: st_be = 4'b0001 << addr_reg[1:0];
            2'd1: st_be = 4'b0011 << addr_reg[1:0];
            default: st_be = 4'b1111;
        endcase
        for (int i = 0; i < 4; i++) begin
            st_word[i*8 +: 8] = st_be[i] ? st_data[i*8 +: 8] : rdata_reg[i*8 +: 8];
        end
        wr_eff  = wr1_reg && rd1 != 5'd0;
        fin_val = !wr_eff ? 32'd0 : (load_reg ? ld_val : val1_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg  <= 1'b0;
            out_v_reg <= 1'b0;
            pc_reg    <= 32'd0;
            clr_reg   <= '0;
        end else begin
            if (clearing) clr_reg <= clr_reg + CW'(1);
            if (cfg_wr_en) pc_reg <= cfg_wr_data;
            if (m_tvalid && m_tready) out_v_reg <= 1'b0;
            if (take) begin
                busy_reg <= 1'b1;
                pc_reg   <= nxt;
            end
            if (busy_reg) begin
                busy_reg  <= 1'b0;
                out_v_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (clearing) mem[clr_reg[AW-1:0]] <= 32'd0;
        else if (busy_reg && store_reg) mem[widx] <= st_word;
        rdata_reg <= mem[(take ? addr[AW+1:2] : widx)];
        if (take) begin
            w_reg <= w; pc1_reg <= pc_reg; b_reg <= b;
            addr_reg <= addr; val1_reg <= val; next1_reg <= nxt; st1_reg <= st;
            wr1_reg <= wr; tk1_reg <= tk; load_reg <= is_ld; store_reg <= is_st;
        end
        if (!aresetn) begin
            for (int i = 0; i < 32; i++) rf[i] <= 32'd0;
        end else if (busy_reg && wr_eff) begin
            rf[rd1] <= fin_val;
        end
        if (busy_reg) begin
            out_reg <= RES_BYTES_W'({st1_reg, addr_reg, store_reg, tk1_reg, wr_eff,
                                     fin_val, (wr1_reg ? rd1 : 5'd0), next1_reg, pc1_reg});
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_reg;
endmodule
`default_nettype wire
